[design/psad_pkg.sv]
// Shared constants for the prefix-sum-along-dimension block.
// Used by the top level and by its port checker; no dependencies.
package psad_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_WIDTH_DEF = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // axis codes
    localparam logic [1:0] DIM_X = 2'd0;
    localparam logic [1:0] DIM_Y = 2'd1;
    localparam logic [1:0] DIM_T = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd4;

    // register reset values
    localparam logic [1:0] DIM_RST = DIM_X;
    localparam logic [8:0] WIDTH_RST = 9'd256;
    localparam logic [8:0] HEIGHT_RST = 9'd256;
    localparam logic [15:0] FRAMES_RST = 16'd1;
    localparam logic [4:0] CHANNELS_RST = 5'd1;

    localparam logic [4:0] MAX_CHANNELS = 5'd16;

    localparam logic [SAMPLE_W-1:0] SUM_MAX = 32'h7fff_ffff;
    localparam logic [SAMPLE_W-1:0] SUM_MIN = 32'h8000_0000;

endpackage

[design/prefix_sum_along_dimension_top.sv]
// Running sum of a raster sample stream along x, y or time, with saturation.
// Depends on psad_pkg for constants; holds the store of previous sums.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one signed Q16.16 sample per
//   transaction, in raster order (x fastest, then y, frame, channel). Output
//   channel o_out_valid / i_out_ready carries one result per sample: the sum,
//   a saturation flag and a flag on the last pixel of the last channel.
//   The configuration port takes a write whenever i_cfg_we is high; any write
//   to a defined register restarts the image counters. Write it only when the
//   block holds no transaction.
//   A sample passes the input stage, then the output register. Throughput is
//   one sample per cycle while results are taken: each sample makes one read
//   of the store when it is accepted and, along y or t, one write when its sum
//   is formed; a sum the store has not returned is taken from the write port.
//   Reset clears the counters, accumulator, pipeline and registers to their
//   defaults; the store itself is not cleared and holds no valid data until a
//   pass along y or t writes it. When the receiver stalls, the result holds
//   in the output register, one more sample waits in the input stage, and
//   o_in_ready drops.
module prefix_sum_along_dimension_top #(
    parameter int MAX_WIDTH = psad_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = psad_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psad_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [psad_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [psad_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [psad_pkg::SAMPLE_W-1:0] o_sum_out,
    output logic                                o_saturated,
    output logic                                o_last_pixel
);

    localparam int SW = psad_pkg::SAMPLE_W;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = $clog2(DEPTH);

    // configuration
    logic [1:0]  r_dim;
    logic [8:0]  r_width;
    logic [8:0]  r_height;
    logic [15:0] r_frames;
    logic [4:0]  r_channels;

    // position counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [15:0]   r_frm;
    logic [3:0]    r_chn;
    logic [SW-1:0] r_acc;

    // input stage
    logic                 r_s1_valid;
    logic signed [SW-1:0] r_s1_sample;
    logic                 r_s1_first;
    logic                 r_s1_last;
    logic [AW-1:0]        r_s1_addr;
    logic                 r_s1_fwd;
    logic [SW-1:0]        r_s1_fwd_data;
    logic [SW-1:0]        r_rdata;

    // output register
    logic                 r_out_valid;
    logic signed [SW-1:0] r_out_sum;
    logic                 r_out_sat;
    logic                 r_out_last;

    logic [SW-1:0] r_store [DEPTH];

    logic [CW-1:0] w_m1;
    logic [RW-1:0] h_m1;
    logic [15:0]   f_m1;
    logic [3:0]    c_m1;
    logic          col_end, row_end, frm_end, chn_end;
    logic [AW-1:0] rd_addr;
    logic          s1_adv, s1_fire, in_accept, wr_en, cfg_hit;
    logic [SW-1:0] operand;
    logic [SW:0]   wide_sum;
    logic [SW-1:0] result;
    logic          result_sat;

    // sizes of zero count as one; oversized values clip to the maximum
    always_comb begin
        if (r_width == 9'd0) begin
            w_m1 = '0;
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_m1 = CW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = CW'(r_width - 9'd1);
        end
        if (r_height == 9'd0) begin
            h_m1 = '0;
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_m1 = RW'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = RW'(r_height - 9'd1);
        end
        f_m1 = (r_frames == 16'd0) ? 16'd0 : r_frames - 16'd1;
        if (r_channels == 5'd0) begin
            c_m1 = 4'd0;
        end else if (r_channels > psad_pkg::MAX_CHANNELS) begin
            c_m1 = 4'(psad_pkg::MAX_CHANNELS - 5'd1);
        end else begin
            c_m1 = 4'(r_channels - 5'd1);
        end
    end

    assign col_end = (r_col == w_m1);
    assign row_end = (r_row == h_m1);
    assign frm_end = (r_frm == f_m1);
    assign chn_end = (r_chn == c_m1);

    assign rd_addr = (r_dim == psad_pkg::DIM_T)
                   ? AW'(r_row) * AW'(MAX_WIDTH) + AW'(r_col)
                   : AW'(r_col);

    assign s1_adv = !r_out_valid || i_out_ready;
    assign s1_fire = r_s1_valid && s1_adv;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept = i_in_valid && o_in_ready;
    assign wr_en = s1_fire && (r_dim inside {psad_pkg::DIM_Y, psad_pkg::DIM_T});
    assign cfg_hit = i_cfg_we && (i_cfg_index inside {psad_pkg::REG_DIM, psad_pkg::REG_WIDTH,
                     psad_pkg::REG_HEIGHT, psad_pkg::REG_FRAMES, psad_pkg::REG_CHANNELS});

    // sum and saturate; the unused axis code always arrives marked first
    always_comb begin
        if (r_dim == psad_pkg::DIM_X) begin
            operand = r_acc;
        end else if (r_s1_fwd) begin
            operand = r_s1_fwd_data;
        end else begin
            operand = r_rdata;
        end
        wide_sum = {r_s1_sample[SW-1], r_s1_sample} + {operand[SW-1], operand};
        result = r_s1_sample;
        result_sat = 1'b0;
        if (!r_s1_first) begin
            if (wide_sum[SW] != wide_sum[SW-1]) begin
                result = wide_sum[SW] ? psad_pkg::SUM_MIN : psad_pkg::SUM_MAX;
                result_sat = 1'b1;
            end else begin
                result = wide_sum[SW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= psad_pkg::DIM_RST;
            r_width <= psad_pkg::WIDTH_RST;
            r_height <= psad_pkg::HEIGHT_RST;
            r_frames <= psad_pkg::FRAMES_RST;
            r_channels <= psad_pkg::CHANNELS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                psad_pkg::REG_DIM:      r_dim <= i_cfg_wdata[1:0];
                psad_pkg::REG_WIDTH:    r_width <= i_cfg_wdata[8:0];
                psad_pkg::REG_HEIGHT:   r_height <= i_cfg_wdata[8:0];
                psad_pkg::REG_FRAMES:   r_frames <= i_cfg_wdata;
                psad_pkg::REG_CHANNELS: r_channels <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // counters and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
            r_frm <= '0;
            r_chn <= '0;
            r_acc <= '0;
        end else begin
            if (in_accept) begin
                if (!col_end) begin
                    r_col <= r_col + CW'(1);
                end else begin
                    r_col <= '0;
                    if (!row_end) begin
                        r_row <= r_row + RW'(1);
                    end else begin
                        r_row <= '0;
                        if (!frm_end) begin
                            r_frm <= r_frm + 16'd1;
                        end else begin
                            r_frm <= '0;
                            r_chn <= chn_end ? 4'd0 : r_chn + 4'd1;
                        end
                    end
                end
            end
            if (s1_fire && (r_dim == psad_pkg::DIM_X)) begin
                r_acc <= result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_sample <= i_sample_in;
            r_s1_addr <= rd_addr;
            r_s1_last <= col_end && row_end && frm_end && chn_end;
            case (r_dim)
                psad_pkg::DIM_X: r_s1_first <= (r_col == '0);
                psad_pkg::DIM_Y: r_s1_first <= (r_row == '0);
                psad_pkg::DIM_T: r_s1_first <= (r_frm == 16'd0);
                default:         r_s1_first <= 1'b1;
            endcase
            // the store returns old data when the previous sum lands in this same edge
            r_s1_fwd <= wr_en && (r_s1_addr == rd_addr);
            r_s1_fwd_data <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rdata <= r_store[rd_addr];
        end
        if (wr_en) begin
            r_store[r_s1_addr] <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_sum <= result;
            r_out_sat <= result_sat;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sum_out = r_out_sum;
    assign o_saturated = r_out_sat;
    assign o_last_pixel = r_out_last;

endmodule

[design/psad_checker.sv]
// Port-level checks for prefix_sum_along_dimension_top, attached by bind.
// Depends on psad_pkg for widths and saturation limits.
module psad_port_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [psad_pkg::SAMPLE_W-1:0] o_sum_out,
    input logic                                 o_saturated,
    input logic                                 o_last_pixel
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sum_out)
        && $stable(o_saturated) && $stable(o_last_pixel))
        else $error("stalled result changed");

    // a clipped sum sits at one of the two limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
        (o_sum_out == psad_pkg::SUM_MAX) || (o_sum_out == psad_pkg::SUM_MIN))
        else $error("saturated sum not at a limit");

    // input side never blocks while the output side drains
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input stalled with free output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind prefix_sum_along_dimension_top psad_port_checker u_psad_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sum_out    (o_sum_out),
    .o_saturated  (o_saturated),
    .o_last_pixel (o_last_pixel)
);
